>>> hdl/ufus_pkg.sv
// Package for the UART flash update sequencer: protocol bytes, codes,
// the result record and the fixed flash sector map.
// Depends on nothing; used by every module of the block.
package ufus_pkg;

  localparam int unsigned CHUNK_BYTES_DEF = 256;
  localparam int unsigned OUTQ_DEPTH      = 4;
  localparam int unsigned OUTQ_PTR_W      = $clog2(OUTQ_DEPTH);

  localparam logic [7:0]  HANDSHAKE     = 8'h7F;
  localparam logic [7:0]  ACK_BYTE      = 8'h79;
  localparam logic [7:0]  NACK_BYTE     = 8'h1F;
  localparam logic [19:0] REMAIN_MAX    = 20'hF_FFFF;
  localparam logic [31:0] APP_BASE_RST  = 32'h0800_8000;
  localparam logic [31:0] FLASH_END_RST = 32'h0808_0000;

  localparam logic [31:0] SECTOR1_BASE = 32'h0800_4000;
  localparam logic [31:0] SECTOR2_BASE = 32'h0800_8000;
  localparam logic [31:0] SECTOR3_BASE = 32'h0800_C000;
  localparam logic [31:0] SECTOR4_BASE = 32'h0801_0000;
  localparam logic [31:0] SECTOR5_BASE = 32'h0802_0000;
  localparam logic [31:0] SECTOR6_BASE = 32'h0804_0000;
  localparam logic [31:0] SECTOR7_BASE = 32'h0806_0000;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_STATUS  = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_ERASE = 2'd1,
    ACT_PROG  = 2'd2,
    ACT_START = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    REG_APP_BASE  = 1'b0,
    REG_FLASH_END = 1'b1
  } reg_idx_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  tx_byte;
    logic [2:0]  erase_first_sector;
    logic [3:0]  erase_sector_count;
    logic [31:0] program_address;
    logic [31:0] program_word;
    logic        last;
  } result_t;

  // Results raised by one request: n is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [2:0] sector_of(logic [31:0] a);
    logic [2:0] s;
    if (a < SECTOR1_BASE)      s = 3'd0;
    else if (a < SECTOR2_BASE) s = 3'd1;
    else if (a < SECTOR3_BASE) s = 3'd2;
    else if (a < SECTOR4_BASE) s = 3'd3;
    else if (a < SECTOR5_BASE) s = 3'd4;
    else if (a < SECTOR6_BASE) s = 3'd5;
    else if (a < SECTOR7_BASE) s = 3'd6;
    else                       s = 3'd7;
    return s;
  endfunction

  function automatic result_t res_blank();
    result_t r;
    r = '0;
    return r;
  endfunction

  function automatic result_t res_send(logic [7:0] b);
    result_t r;
    r = '0;
    r.action  = ACT_SEND;
    r.tx_byte = b;
    r.last    = 1'b1;
    return r;
  endfunction

endpackage

>>> hdl/uart_flash_update_sequencer.sv
// Top level of the UART flash update sequencer: configuration registers,
// request handshake, protocol core and result queue.
// Depends on ufus_pkg, ufus_core and ufus_outq.
//
// One request is taken in every cycle. Its effect on the protocol state is
// worked out in the cycle it is taken, and its results (none, one or two)
// go into a four-entry result queue, which registers them before they are
// offered. A request is held off only while the queue holds more than two
// results, which happens only when the result side stalls; a request that
// raises two results is drained one result at a time on the result side.
module uart_flash_update_sequencer import ufus_pkg::*; #(
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        flash_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [7:0]  tx_byte_o,
  output logic [2:0]  erase_first_sector_o,
  output logic [3:0]  erase_sector_count_o,
  output logic [31:0] program_address_o,
  output logic [31:0] program_word_o,
  output logic        last_o
);

  logic [31:0] app_base_q, flash_end_q;
  logic        accept;
  push_t       push;
  result_t     head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_base_q  <= APP_BASE_RST;
      flash_end_q <= FLASH_END_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_APP_BASE:  app_base_q  <= cfg_wdata_i;
        REG_FLASH_END: flash_end_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  ufus_core #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (command_i),
    .rx_byte_i  (rx_byte_i),
    .flash_ok_i (flash_ok_i),
    .app_base_i (app_base_q),
    .flash_end_i(flash_end_q),
    .push_o     (push)
  );

  ufus_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .has_room_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (head)
  );

  assign action_o             = head.action;
  assign tx_byte_o            = head.tx_byte;
  assign erase_first_sector_o = head.erase_first_sector;
  assign erase_sector_count_o = head.erase_sector_count;
  assign program_address_o    = head.program_address;
  assign program_word_o       = head.program_word;
  assign last_o               = head.last;

  // Two results come only from the final chunk: acknowledge, then start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd2 |-> (!push.r0.last && push.r0.action == ACT_SEND &&
                        push.r1.action == ACT_START && push.r1.last))
  else $error("double result is not acknowledge followed by start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> push.n == 2'd0)
  else $error("results raised without a request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
  else $error("requests held off while no result is waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_PROG || action_o == ACT_ERASE)) |-> last_o)
  else $error("erase or program result not marked last");

endmodule

>>> hdl/ufus_core.sv
// Protocol state and the single-pass next-state and result logic of the
// flash update sequencer. Depends on ufus_pkg.
module ufus_core import ufus_pkg::*; #(
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        flash_ok_i,
  input  logic [31:0] app_base_i,
  input  logic [31:0] flash_end_i,
  output push_t       push_o
);

  localparam int unsigned CntW = $clog2(CHUNK_BYTES + 1);

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_SIZE  = 7'b0000010,
    PH_ERASE = 7'b0000100,
    PH_DATA  = 7'b0001000,
    PH_PROG  = 7'b0010000,
    PH_HALT  = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [31:0]       size_q, size_d;
  logic [1:0]        size_cnt_q, size_cnt_d;
  logic [19:0]       remain_q, remain_d;
  logic [CntW-1:0]   chunk_q, chunk_d;
  logic [31:0]       word_q, word_d;
  logic [1:0]        biw_q, biw_d;
  logic [31:0]       wp_q, wp_d;
  logic              pend_q, pend_d;

  logic [31:0]       size_full, limit, end_addr, word_new;
  logic [2:0]        first_sec, last_sec;
  logic [19:0]       remain_new;
  logic [CntW-1:0]   chunk_new;
  logic              chunk_end;
  logic [1:0]        n;
  result_t           r0, r1;

  always_comb begin
    size_full  = size_q | ({24'h0, rx_byte_i} << {size_cnt_q, 3'b000});
    limit      = (flash_end_i > app_base_i) ? flash_end_i - app_base_i : 32'h0;
    end_addr   = app_base_i + size_full - 32'd1;
    first_sec  = sector_of(app_base_i);
    last_sec   = sector_of(end_addr);
    if (last_sec < first_sec) begin
      last_sec = first_sec;
    end
    word_new = word_q;
    for (int l = 0; l < 4; l++) begin
      if (biw_q == l[1:0]) begin
        word_new[8*l +: 8] = rx_byte_i;
      end
    end
    remain_new = remain_q - {19'h0, (remain_q != 20'h0)};
    chunk_new  = chunk_q + CntW'(1);
    chunk_end  = (chunk_new >= CntW'(CHUNK_BYTES)) || (remain_new == 20'h0);
  end

  always_comb begin
    phase_d    = phase_q;
    size_d     = size_q;
    size_cnt_d = size_cnt_q;
    remain_d   = remain_q;
    chunk_d    = chunk_q;
    word_d     = word_q;
    biw_d      = biw_q;
    wp_d       = wp_q;
    pend_d     = pend_q;
    n          = 2'd0;
    r0         = res_blank();
    r1         = res_blank();
    case (phase_q)
      PH_IDLE: begin
        if (command_i == CMD_BYTE && rx_byte_i == HANDSHAKE) begin
          n          = 2'd1;
          r0         = res_send(ACK_BYTE);
          size_d     = 32'h0;
          size_cnt_d = 2'd0;
          phase_d    = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (command_i == CMD_TIMEOUT) begin
          n       = 2'd1;
          r0      = res_send(NACK_BYTE);
          phase_d = PH_HALT;
        end else if (command_i == CMD_BYTE) begin
          size_d = size_full;
          if (size_cnt_q != 2'd3) begin
            size_cnt_d = size_cnt_q + 2'd1;
          end else begin
            size_cnt_d = 2'd0;
            n          = 2'd1;
            if (size_full == 32'h0 || size_full > limit ||
                size_full > {12'h0, REMAIN_MAX}) begin
              r0      = res_send(NACK_BYTE);
              phase_d = PH_HALT;
            end else begin
              remain_d              = size_full[19:0];
              r0.action             = ACT_ERASE;
              r0.erase_first_sector = first_sec;
              r0.erase_sector_count = {1'b0, last_sec} - {1'b0, first_sec} + 4'd1;
              r0.last               = 1'b1;
              phase_d               = PH_ERASE;
            end
          end
        end
      end
      PH_ERASE: begin
        if (command_i == CMD_STATUS) begin
          n = 2'd1;
          if (!flash_ok_i) begin
            r0      = res_send(NACK_BYTE);
            phase_d = PH_HALT;
          end else begin
            r0      = res_send(ACK_BYTE);
            wp_d    = app_base_i;
            chunk_d = '0;
            word_d  = '1;
            biw_d   = 2'd0;
            pend_d  = 1'b0;
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (command_i == CMD_TIMEOUT) begin
          n       = 2'd1;
          r0      = res_send(NACK_BYTE);
          phase_d = PH_HALT;
        end else if (command_i == CMD_BYTE) begin
          remain_d = remain_new;
          chunk_d  = chunk_new;
          if (biw_q != 2'd3 && !chunk_end) begin
            word_d = word_new;
            biw_d  = biw_q + 2'd1;
          end else begin
            n                  = 2'd1;
            r0.action          = ACT_PROG;
            r0.program_address = wp_q;
            r0.program_word    = word_new;
            r0.last            = 1'b1;
            wp_d               = wp_q + {30'h0, biw_q} + 32'd1;
            word_d             = '1;
            biw_d              = 2'd0;
            pend_d             = chunk_end;
            phase_d            = PH_PROG;
          end
        end
      end
      PH_PROG: begin
        if (command_i == CMD_STATUS) begin
          if (!flash_ok_i) begin
            n       = 2'd1;
            r0      = res_send(NACK_BYTE);
            phase_d = PH_HALT;
          end else if (!pend_q) begin
            phase_d = PH_DATA;
          end else begin
            pend_d  = 1'b0;
            chunk_d = '0;
            r0      = res_send(ACK_BYTE);
            if (remain_q == 20'h0) begin
              n         = 2'd2;
              r0.last   = 1'b0;
              r1.action = ACT_START;
              r1.last   = 1'b1;
              phase_d   = PH_DONE;
            end else begin
              n       = 2'd1;
              phase_d = PH_DATA;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      size_q     <= 32'h0;
      size_cnt_q <= 2'd0;
      remain_q   <= 20'h0;
      chunk_q    <= '0;
      word_q     <= '1;
      biw_q      <= 2'd0;
      wp_q       <= APP_BASE_RST;
      pend_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      size_q     <= size_d;
      size_cnt_q <= size_cnt_d;
      remain_q   <= remain_d;
      chunk_q    <= chunk_d;
      word_q     <= word_d;
      biw_q      <= biw_d;
      wp_q       <= wp_d;
      pend_q     <= pend_d;
    end
  end

  assign push_o.n  = accept_i ? n : 2'd0;
  assign push_o.r0 = r0;
  assign push_o.r1 = r1;

endmodule

>>> hdl/ufus_outq.sv
// Result queue of the flash update sequencer: takes up to two results a
// cycle and hands them out one at a time. Depends on ufus_pkg.
module ufus_outq import ufus_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    has_room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  localparam int unsigned CntW = $clog2(OUTQ_DEPTH + 1);

  result_t               mem_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[head_q];
  assign pop         = out_valid_o && out_ready_i;
  assign has_room_o  = (count_q <= CntW'(OUTQ_DEPTH - 2));

  always_comb begin
    head_d  = head_q + OUTQ_PTR_W'(pop);
    tail_d  = tail_q + OUTQ_PTR_W'(push_i.n);
    count_d = count_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[tail_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[tail_q + OUTQ_PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

>>> test/tb_uart_flash_update_sequencer.sv
// Self-checking testbench for the UART flash update sequencer: it drives one
// update session of host bytes, flash status and timeouts, predicts every
// result and checks it field by field. Depends on ufus_pkg and the RTL top.
module tb_uart_flash_update_sequencer;
  import ufus_pkg::*;

  localparam int unsigned CHUNK       = CHUNK_BYTES_DEF;
  localparam int          STALL_LIMIT = 3000;
  localparam int          HOLD_AT     = 60;
  localparam int          HOLD_CYCLES = 300;
  localparam int          IDLE_PCT    = 38;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [31:0] SECTOR_START [1:7] = '{SECTOR1_BASE, SECTOR2_BASE, SECTOR3_BASE,
                                                 SECTOR4_BASE, SECTOR5_BASE, SECTOR6_BASE,
                                                 SECTOR7_BASE};

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_SIZE, SEQ_ERASE_WAIT, SEQ_DATA, SEQ_PROG_WAIT, SEQ_HALTED, SEQ_DONE
  } seq_phase_e;

  typedef enum logic [1:0] {
    END_START_APP, END_RX_TIMEOUT, END_PROG_FAIL
  } session_end_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_APP_BASE;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = CMD_BYTE;
  logic [7:0]  rx_byte_i = '0;
  logic        flash_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  action_o;
  logic [7:0]  tx_byte_o;
  logic [2:0]  erase_first_sector_o;
  logic [3:0]  erase_sector_count_o;
  logic [31:0] program_address_o;
  logic [31:0] program_word_o;
  logic        last_o;

  uart_flash_update_sequencer #(.CHUNK_BYTES(CHUNK)) uut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Shadow of the sequencer: configuration, protocol state and results owed.
  logic [31:0] win_app_base = APP_BASE_RST;
  logic [31:0] win_flash_end = FLASH_END_RST;
  seq_phase_e  seq_phase = SEQ_IDLE;
  logic [31:0] size_acc = '0;
  int          size_bytes_seen = 0;
  logic [19:0] bytes_left = '0;
  int          chunk_fill = 0;
  logic [31:0] word_acc = '1;
  int          word_fill = 0;
  logic [31:0] next_addr = APP_BASE_RST;
  logic        chunk_closing = 1'b0;
  result_t     owed_results [$];

  logic        calm = 1'b0;
  logic        held_once = 1'b0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          n_requests = 0;
  int          n_results = 0;
  int          n_words = 0;
  logic [31:0] image_size;
  logic [2:0]  erased_first = '0;
  logic [3:0]  erased_count = '0;
  string       ending_text = "none";

  function automatic logic [2:0] sector_at(logic [31:0] a);
    logic [2:0] s;
    s = '0;
    for (int k = 1; k < 8; k++) if (a >= SECTOR_START[k]) s = 3'(k);
    return s;
  endfunction

  function automatic void owe(action_e a, logic [7:0] tx, logic [2:0] fs, logic [3:0] cnt,
                              logic [31:0] addr, logic [31:0] w, logic lst);
    result_t r;
    r.action = a;
    r.tx_byte = tx;
    r.erase_first_sector = fs;
    r.erase_sector_count = cnt;
    r.program_address = addr;
    r.program_word = w;
    r.last = lst;
    owed_results.push_back(r);
  endfunction

  function automatic void halt_with_nack();
    owe(ACT_SEND, NACK_BYTE, '0, '0, '0, '0, 1'b1);
    seq_phase = SEQ_HALTED;
  endfunction

  function automatic void track_request(logic [1:0] c, logic [7:0] b, logic ok);
    logic [31:0] limit;
    logic [2:0]  first, lastsec;
    logic        chunk_end;
    case (seq_phase)
      SEQ_IDLE: begin
        if (c == CMD_BYTE && b == HANDSHAKE) begin
          owe(ACT_SEND, ACK_BYTE, '0, '0, '0, '0, 1'b1);
          size_acc = '0;
          size_bytes_seen = 0;
          seq_phase = SEQ_SIZE;
        end
      end
      SEQ_SIZE: begin
        if (c == CMD_TIMEOUT) begin
          halt_with_nack();
        end else if (c == CMD_BYTE) begin
          size_acc[8*size_bytes_seen +: 8] = b;
          if (size_bytes_seen < 3) begin
            size_bytes_seen++;
          end else begin
            size_bytes_seen = 0;
            limit = (win_flash_end > win_app_base) ? win_flash_end - win_app_base : '0;
            if (size_acc == 0 || size_acc > limit || size_acc > 32'(REMAIN_MAX)) begin
              halt_with_nack();
            end else begin
              bytes_left = size_acc[19:0];
              first = sector_at(win_app_base);
              lastsec = sector_at(win_app_base + size_acc - 1);
              if (lastsec < first) lastsec = first;
              erased_first = first;
              erased_count = 4'(lastsec - first) + 4'd1;
              owe(ACT_ERASE, '0, first, erased_count, '0, '0, 1'b1);
              seq_phase = SEQ_ERASE_WAIT;
            end
          end
        end
      end
      SEQ_ERASE_WAIT: begin
        if (c == CMD_STATUS && !ok) begin
          halt_with_nack();
        end else if (c == CMD_STATUS) begin
          owe(ACT_SEND, ACK_BYTE, '0, '0, '0, '0, 1'b1);
          next_addr = win_app_base;
          chunk_fill = 0;
          word_acc = '1;
          word_fill = 0;
          chunk_closing = 1'b0;
          seq_phase = SEQ_DATA;
        end
      end
      SEQ_DATA: begin
        if (c == CMD_TIMEOUT) begin
          halt_with_nack();
        end else if (c == CMD_BYTE) begin
          word_acc[8*word_fill +: 8] = b;
          word_fill++;
          chunk_fill++;
          if (bytes_left != 0) bytes_left--;
          chunk_end = (chunk_fill >= CHUNK) || (bytes_left == 0);
          if (word_fill == 4 || chunk_end) begin
            owe(ACT_PROG, '0, '0, '0, next_addr, word_acc, 1'b1);
            n_words++;
            next_addr += 32'(word_fill);
            word_acc = '1;
            word_fill = 0;
            chunk_closing = chunk_end;
            seq_phase = SEQ_PROG_WAIT;
          end
        end
      end
      SEQ_PROG_WAIT: begin
        if (c == CMD_STATUS && !ok) begin
          halt_with_nack();
        end else if (c == CMD_STATUS && !chunk_closing) begin
          seq_phase = SEQ_DATA;
        end else if (c == CMD_STATUS) begin
          chunk_closing = 1'b0;
          chunk_fill = 0;
          if (bytes_left == 0) begin
            owe(ACT_SEND, ACK_BYTE, '0, '0, '0, '0, 1'b0);
            owe(ACT_START, '0, '0, '0, '0, '0, 1'b1);
            seq_phase = SEQ_DONE;
          end else begin
            owe(ACT_SEND, ACK_BYTE, '0, '0, '0, '0, 1'b1);
            seq_phase = SEQ_DATA;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [1:0] c, logic [7:0] b, logic ok);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= c;
    rx_byte_i <= b;
    flash_ok_i <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_requests++;
    track_request(c, b, ok);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_window(logic [31:0] app, logic [31:0] fend);
    wait_quiet();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_APP_BASE;
    cfg_wdata_i <= app;
    @(posedge clk_i);
    cfg_idx_i <= REG_FLASH_END;
    cfg_wdata_i <= fend;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_app_base = app;
    win_flash_end = fend;
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic test_idle_strays();
    set_window(32'hFFFF_FFFF, 32'h0);
    send_request(CMD_BYTE, 8'h00, 1'b0);
    send_request(CMD_BYTE, 8'hFF, 1'b1);
    send_request(CMD_BYTE, 8'h7E, 1'b0);
    send_request(CMD_STATUS, pick_byte(), 1'($urandom));
    send_request(CMD_TIMEOUT, HANDSHAKE, 1'b1);
    send_request(CMD_UNUSED, HANDSHAKE, 1'b0);
  endtask

  task automatic test_handshake();
    logic [31:0] app, fend;
    int          k;
    image_size = $urandom_range(1250, 1450);
    case ($urandom_range(0, 3))
      0: begin
        app = APP_BASE_RST;
        fend = FLASH_END_RST;
      end
      1: begin
        k = $urandom_range(1, 7);
        app = SECTOR_START[k] - $urandom_range(1, image_size - 1);
        fend = 32'hFFFF_FFFF;
      end
      2: begin
        app = '0;
        fend = image_size;
      end
      default: begin
        app = SECTOR7_BASE + $urandom_range(0, 32'h1_0000);
        fend = FLASH_END_RST;
      end
    endcase
    set_window(app, fend);
    send_request(CMD_BYTE, HANDSHAKE, 1'($urandom));
  endtask

  task automatic test_size_field();
    send_request(CMD_STATUS, pick_byte(), 1'b1);
    send_request(CMD_UNUSED, pick_byte(), 1'b0);
    for (int k = 0; k < 4; k++) send_request(CMD_BYTE, image_size[8*k +: 8], 1'($urandom));
  endtask

  task automatic test_erase();
    set_window($urandom_range(0, 1) ? $urandom : win_app_base, win_flash_end);
    send_request(CMD_BYTE, pick_byte(), 1'b0);
    send_request(CMD_TIMEOUT, pick_byte(), 1'b0);
    send_request(CMD_UNUSED, pick_byte(), 1'b1);
    send_request(CMD_STATUS, pick_byte(), 1'b1);
  endtask

  task automatic test_data_directed();
    send_request(CMD_BYTE, 8'h00, 1'b1);
    send_request(CMD_STATUS, pick_byte(), 1'b0);
    send_request(CMD_BYTE, 8'hFF, 1'b0);
    send_request(CMD_UNUSED, pick_byte(), 1'b0);
    send_request(CMD_BYTE, 8'hA5, 1'b1);
    send_request(CMD_BYTE, 8'h5A, 1'b0);
    send_request(CMD_BYTE, pick_byte(), 1'b1);
    send_request(CMD_TIMEOUT, pick_byte(), 1'b0);
    send_request(CMD_UNUSED, pick_byte(), 1'b1);
    send_request(CMD_STATUS, pick_byte(), 1'b1);
  endtask

  task automatic test_random_image();
    session_end_e how;
    logic [19:0]  end_at;
    int           step;
    how = session_end_e'($urandom_range(0, 2));
    end_at = 20'($urandom_range(1, 64));
    step = 0;
    while (seq_phase != SEQ_DONE && seq_phase != SEQ_HALTED) begin
      step++;
      if (step == 400) calm = 1'b1;
      if (step == 700) calm = 1'b0;
      if (step == 900) set_window('0, 32'hFFFF_FFFF);
      if (step == 1200) set_window(32'hFFFF_FFFF, '0);
      if (how == END_RX_TIMEOUT && seq_phase == SEQ_DATA && bytes_left <= end_at) begin
        ending_text = "a receive timeout";
        send_request(CMD_TIMEOUT, pick_byte(), 1'($urandom));
      end else if (how == END_PROG_FAIL && seq_phase == SEQ_PROG_WAIT &&
                   bytes_left <= end_at) begin
        ending_text = "a failed program status";
        send_request(CMD_STATUS, pick_byte(), 1'b0);
      end else if (seq_phase == SEQ_DATA) begin
        if ($urandom_range(0, 99) < 92)
          send_request(CMD_BYTE, pick_byte(), 1'($urandom));
        else
          send_request($urandom_range(0, 1) ? CMD_STATUS : CMD_UNUSED, pick_byte(),
                       1'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0: send_request(CMD_BYTE, pick_byte(), 1'($urandom));
          1: send_request(CMD_TIMEOUT, pick_byte(), 1'($urandom));
          2: send_request(CMD_UNUSED, pick_byte(), 1'($urandom));
          default: send_request(CMD_STATUS, pick_byte(), 1'b1);
        endcase
      end
    end
    if (seq_phase == SEQ_DONE) ending_text = "start of the application";
  endtask

  task automatic test_after_end();
    send_request(CMD_BYTE, HANDSHAKE, 1'b1);
    send_request(CMD_STATUS, pick_byte(), 1'b1);
    send_request(CMD_STATUS, pick_byte(), 1'b0);
    send_request(CMD_TIMEOUT, pick_byte(), 1'b0);
    send_request(CMD_UNUSED, pick_byte(), 1'b1);
    send_request(CMD_BYTE, pick_byte(), 1'b0);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_side
    result_t want;
    if (out_valid_o && out_ready_i) begin
      n_results++;
      if (owed_results.size() == 0) begin
        mismatches++;
        $error("unexpected result with action %0d", action_o);
      end else begin
        want = owed_results.pop_front();
        check_field("action", 32'(want.action), 32'(action_o));
        check_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte_o));
        check_field("erase_first_sector", 32'(want.erase_first_sector),
                    32'(erase_first_sector_o));
        check_field("erase_sector_count", 32'(want.erase_sector_count),
                    32'(erase_sector_count_o));
        check_field("program_address", want.program_address, program_address_o);
        check_field("program_word", want.program_word, program_word_o);
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!held_once && n_results >= HOLD_AT) begin
      held_once <= 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no request or result moved for %0d cycles.", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : run_tests
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_strays();
    test_handshake();
    test_size_field();
    test_erase();
    test_data_directed();
    test_random_image();
    test_after_end();
    wait_quiet();
    repeat (16) @(posedge clk_i);
    $display("Session of %0d image bytes: %0d requests, %0d results, %0d words programmed.",
             image_size, n_requests, n_results, n_words);
    $display("Erase of %0d sector(s) from sector %0d; the session ended with %s.",
             erased_count, erased_first, ending_text);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> uart_flash_update_sequencer.f
hdl/ufus_pkg.sv
hdl/ufus_core.sv
hdl/ufus_outq.sv
hdl/uart_flash_update_sequencer.sv
test/tb_uart_flash_update_sequencer.sv
